// ===== rtl/scl3x_pkg.sv =====
// Package: shared constants for the 3x pixel-art magnifier.
package scl3x_pkg;

  // Rows of one input column of the 3-row window
  localparam int unsigned COL_ROWS   = 3;
  localparam int unsigned ROW_ABOVE  = 0;
  localparam int unsigned ROW_CENTER = 1;
  localparam int unsigned ROW_BELOW  = 2;

endpackage

// ===== rtl/scl3x_in_if.sv =====
// Interface: input column channel (valid/ready plus one window column).
interface scl3x_in_if #(
  parameter int unsigned PIXEL_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] above_pixel;
  logic [PIXEL_BITS-1:0] center_pixel;
  logic [PIXEL_BITS-1:0] below_pixel;
  logic                  first_in_line;
  logic                  last_in_line;

  modport source (
    output valid, above_pixel, center_pixel, below_pixel, first_in_line, last_in_line,
    input  ready
  );
  modport sink (
    input  valid, above_pixel, center_pixel, below_pixel, first_in_line, last_in_line,
    output ready
  );
endinterface

// ===== rtl/scl3x_out_if.sv =====
// Interface: output 3x3 block channel (valid/ready plus nine pixels and line flag).
interface scl3x_out_if #(
  parameter int unsigned PIXEL_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] top_left;
  logic [PIXEL_BITS-1:0] top_mid;
  logic [PIXEL_BITS-1:0] top_right;
  logic [PIXEL_BITS-1:0] mid_left;
  logic [PIXEL_BITS-1:0] mid_center;
  logic [PIXEL_BITS-1:0] mid_right;
  logic [PIXEL_BITS-1:0] bottom_left;
  logic [PIXEL_BITS-1:0] bottom_mid;
  logic [PIXEL_BITS-1:0] bottom_right;
  logic                  line_done;

  modport source (
    output valid, top_left, top_mid, top_right, mid_left, mid_center, mid_right,
           bottom_left, bottom_mid, bottom_right, line_done,
    input  ready
  );
  modport sink (
    input  valid, top_left, top_mid, top_right, mid_left, mid_center, mid_right,
           bottom_left, bottom_mid, bottom_right, line_done,
    output ready
  );
endinterface

// ===== rtl/pixel_art_scale3x.sv =====
// Top level: 3x pixel-art magnifier, one window column in, one 3x3 block per result out.
// Path: a completed window is registered in the job register, then in the output register;
//   an edge block queued behind an inner block follows it into the output register.
// Throughput: 1 column per cycle while the output is not stalled; a column that closes a
//   line after an inner column holds off the input while its second block goes out.
// Reset: rst_n synchronous, active low; clears window-valid, job flags and output valid.
module pixel_art_scale3x #(
  parameter int unsigned PIXEL_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  scl3x_in_if.sink    in_chan,
  scl3x_out_if.source out_chan
);

  typedef logic [PIXEL_BITS-1:0] pix_t;

  // Window state: column whose block is pending and its left neighbor
  pix_t prev_r  [scl3x_pkg::COL_ROWS];
  pix_t pprev_r [scl3x_pkg::COL_ROWS];
  logic wvalid_r;

  // Job register: up to two blocks waiting for the output register.
  //   inner block: (job_l, job_c, job_r)
  //   edge block : (had_inner ? job_c : job_r, job_r, job_r)
  pix_t job_l_r [scl3x_pkg::COL_ROWS];
  pix_t job_c_r [scl3x_pkg::COL_ROWS];
  pix_t job_r_r [scl3x_pkg::COL_ROWS];
  logic inner_r;      // inner block still to send
  logic last_r;       // edge block still to send
  logic had_inner_r;  // job carried an inner block

  // Output register
  logic out_valid_r;
  pix_t o_r [9];
  logic done_r;

  pix_t cur [scl3x_pkg::COL_ROWS];
  logic in_acc;
  logic start;
  logic job_busy;
  logic out_load;

  assign cur[scl3x_pkg::ROW_ABOVE]  = in_chan.above_pixel;
  assign cur[scl3x_pkg::ROW_CENTER] = in_chan.center_pixel;
  assign cur[scl3x_pkg::ROW_BELOW]  = in_chan.below_pixel;

  // A column starts a new line on the first flag, or when nothing is pending.
  // A pending column of an unfinished line is simply dropped.
  assign start = in_chan.first_in_line | ~wvalid_r;

  // Output register takes a block whenever it is empty or being drained
  assign job_busy = inner_r | last_r;
  assign out_load = job_busy & (~out_valid_r | out_chan.ready);

  // Accept when the job register is free or its last block leaves this cycle
  assign in_chan.ready = ~job_busy | (out_load & ~(inner_r & last_r));
  assign in_acc        = in_chan.valid & in_chan.ready;

  // Block selection: inner block first, edge block after
  pix_t sel_l [scl3x_pkg::COL_ROWS];
  pix_t sel_c [scl3x_pkg::COL_ROWS];
  pix_t sel_r [scl3x_pkg::COL_ROWS];

  always_comb begin
    for (int k = 0; k < scl3x_pkg::COL_ROWS; k++) begin
      if (inner_r) begin
        sel_l[k] = job_l_r[k];
        sel_c[k] = job_c_r[k];
      end else begin
        sel_l[k] = had_inner_r ? job_c_r[k] : job_r_r[k];
        sel_c[k] = job_r_r[k];
      end
      sel_r[k] = job_r_r[k];
    end
  end

  // Scale3x rules on the neighborhood
  //   A B C
  //   D E F
  //   G H I
  pix_t pa, pb, pc, pd, pe, pf, pg, ph, pi;
  pix_t blk [9];
  logic db, bf, dh, hf;

  always_comb begin
    pa = sel_l[scl3x_pkg::ROW_ABOVE];
    pd = sel_l[scl3x_pkg::ROW_CENTER];
    pg = sel_l[scl3x_pkg::ROW_BELOW];
    pb = sel_c[scl3x_pkg::ROW_ABOVE];
    pe = sel_c[scl3x_pkg::ROW_CENTER];
    ph = sel_c[scl3x_pkg::ROW_BELOW];
    pc = sel_r[scl3x_pkg::ROW_ABOVE];
    pf = sel_r[scl3x_pkg::ROW_CENTER];
    pi = sel_r[scl3x_pkg::ROW_BELOW];

    db = (pd == pb);
    bf = (pb == pf);
    dh = (pd == ph);
    hf = (ph == pf);

    for (int k = 0; k < 9; k++) begin
      blk[k] = pe;
    end
    // Only active where the block is not a flat run vertically or horizontally
    if ((pb != ph) && (pd != pf)) begin
      if (db) blk[0] = pd;
      if ((db && (pe != pc)) || (bf && (pe != pa))) blk[1] = pb;
      if (bf) blk[2] = pf;
      if ((db && (pe != pg)) || (dh && (pe != pa))) blk[3] = pd;
      if ((bf && (pe != pi)) || (hf && (pe != pc))) blk[5] = pf;
      if (dh) blk[6] = pd;
      if ((dh && (pe != pi)) || (hf && (pe != pg))) blk[7] = ph;
      if (hf) blk[8] = pf;
    end
  end

  // Window state and job register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvalid_r    <= 1'b0;
      inner_r     <= 1'b0;
      last_r      <= 1'b0;
      had_inner_r <= 1'b0;
    end else if (in_acc) begin
      wvalid_r    <= ~in_chan.last_in_line;
      inner_r     <= ~start;
      last_r      <= in_chan.last_in_line;
      had_inner_r <= ~start;
    end else if (out_load) begin
      if (inner_r) begin
        inner_r <= 1'b0;
      end else begin
        last_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < scl3x_pkg::COL_ROWS; k++) begin
        job_l_r[k] <= pprev_r[k];
        job_c_r[k] <= prev_r[k];
        job_r_r[k] <= cur[k];
        pprev_r[k] <= start ? cur[k] : prev_r[k];
        prev_r[k]  <= cur[k];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_r    <= blk;
      done_r <= ~inner_r;  // edge block closes the line
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.top_left     = o_r[0];
  assign out_chan.top_mid      = o_r[1];
  assign out_chan.top_right    = o_r[2];
  assign out_chan.mid_left     = o_r[3];
  assign out_chan.mid_center   = o_r[4];
  assign out_chan.mid_right    = o_r[5];
  assign out_chan.bottom_left  = o_r[6];
  assign out_chan.bottom_mid   = o_r[7];
  assign out_chan.bottom_right = o_r[8];
  assign out_chan.line_done    = done_r;

endmodule

// ===== rtl/scl3x_checker.sv =====
// Checker: port-level assertions for the 3x magnifier, bound to the top level.
module scl3x_checker #(
  parameter int unsigned PIXEL_BITS = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [PIXEL_BITS-1:0] top_left,
  input logic [PIXEL_BITS-1:0] top_mid,
  input logic [PIXEL_BITS-1:0] top_right,
  input logic [PIXEL_BITS-1:0] mid_center,
  input logic [PIXEL_BITS-1:0] bottom_left,
  input logic [PIXEL_BITS-1:0] bottom_mid,
  input logic [PIXEL_BITS-1:0] bottom_right,
  input logic                  line_done
);

  // A stalled result transaction stays valid and holds its middle column and line flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(top_mid) && $stable(mid_center)
      && $stable(bottom_mid) && $stable(line_done))
    else $error("output changed while stalled");

  // Input is only held off when a result is on its way out
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> out_valid)
    else $error("input stalled with no result following");

  // Top edge pixel differs from center only if a corner takes the same value
  a_top_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (top_mid != mid_center) |-> (top_left == top_mid) || (top_right == top_mid))
    else $error("top_mid without matching corner");

  a_bottom_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (bottom_mid != mid_center)
      |-> (bottom_left == bottom_mid) || (bottom_right == bottom_mid))
    else $error("bottom_mid without matching corner");

endmodule

bind pixel_art_scale3x scl3x_checker #(
  .PIXEL_BITS(PIXEL_BITS)
) u_scl3x_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .top_left    (out_chan.top_left),
  .top_mid     (out_chan.top_mid),
  .top_right   (out_chan.top_right),
  .mid_center  (out_chan.mid_center),
  .bottom_left (out_chan.bottom_left),
  .bottom_mid  (out_chan.bottom_mid),
  .bottom_right(out_chan.bottom_right),
  .line_done   (out_chan.line_done)
);
